[rtl/bba_pkg.sv]
`default_nettype none
package bba_pkg;

    // free map word geometry
    localparam int WORD_W   = 32;
    localparam int WORD_LOG = 5;

    // fixed field widths
    localparam int ORD_W   = 4;
    localparam int ORD_N   = 16;
    localparam int REQ_W   = 18;
    localparam int NEED_W  = 19;
    localparam int OFF_W   = 22;
    localparam int HDR_W   = 7;
    localparam int STAT_W  = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef logic [STAT_W-1:0] status_t;
    typedef logic [ORD_W-1:0]  order_t;

    localparam logic [HDR_W-1:0] HDR_RESET = 7'd40;

    // register indexes
    localparam logic REG_HDR = 1'b0;

    // commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NOFREE  = 2'd1;
    localparam status_t ST_SIZE    = 2'd2;
    localparam status_t ST_BADFREE = 2'd3;

    // first free map word of order o; each order starts on a word boundary
    function automatic int unsigned bba_word_base(input int unsigned o,
                                                  input int unsigned ng);
        int unsigned b;
        b = 0;
        for (int unsigned k = 0; k < o; k++)
        begin
            b += ((ng >> k) + WORD_W - 1) >> WORD_LOG;
        end
        return b;
    endfunction

endpackage
`default_nettype wire

[rtl/bba_if.sv]
`default_nettype none
interface bba_req_if import bba_pkg::*;;
    logic             valid;
    logic             ready;
    logic             command;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] block_offset;

    modport source (output valid, command, request_bytes, block_offset, input ready);
    modport sink   (input valid, command, request_bytes, block_offset, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*;;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  granted_offset;
    logic [ORD_W-1:0]  granted_order;

    modport source (output valid, status, granted_offset, granted_order, input ready);
    modport sink   (input valid, status, granted_offset, granted_order, output ready);
endinterface
`default_nettype wire

[rtl/bba_ram.sv]
`default_nettype none
module bba_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [W-1:0]             wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [W-1:0]             rdata
);

    logic [W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/bba_cfg.sv]
`default_nettype none
module bba_cfg import bba_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic      [HDR_W-1:0]   header_bytes
);

    logic [HDR_W-1:0] hdr_reg;

    assign pready       = 1'b1;
    assign header_bytes = hdr_reg;

    // register write on the access beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg <= HDR_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_HDR))
        begin
            hdr_reg <= pwdata[HDR_W-1:0];
        end
    end

    // readback
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_HDR)
        begin
            prdata = PDATA_W'(hdr_reg);
        end
    end

endmodule
`default_nettype wire

[rtl/buddy_block_allocator_unit.sv]
`default_nettype none
// Channel  Dir  Beat contents
// req      in   command, request_bytes, block_offset
// rsp      out  status, granted_offset, granted_order (one beat per req beat)
// apb      in   header_bytes at byte address 0
//
// One item at a time through a small sequencer around the free map word RAM and
// the granule order table. Allocate tries orders upward, scans free map words, then
// splits. Free checks the offset and its order, then merges with free buddies upward.
// After reset a clearing pass sweeps both RAMs; req is held off meanwhile, APB
// writes still land. A finished result waits in the rsp register; the next beat
// is taken after it loads.
module buddy_block_allocator_unit import bba_pkg::*; #(
    parameter int TOP_BLOCKS    = 32,
    parameter int TOP_ORDER     = 10,
    parameter int MIN_BLOCK_LOG = 7
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    bba_req_if.sink                 req,
    bba_rsp_if.source               rsp
);

    localparam int NG       = TOP_BLOCKS << TOP_ORDER;
    localparam int GW       = $clog2(NG);
    localparam int FM_DEPTH = bba_word_base(TOP_ORDER + 1, NG);
    localparam int AW       = $clog2(FM_DEPTH);
    localparam int CW       = $clog2(NG + 1);
    localparam int CLR_N    = (NG > FM_DEPTH) ? NG : FM_DEPTH;
    localparam int CLRW     = $clog2(CLR_N);
    localparam int WBT      = bba_word_base(TOP_ORDER, NG);
    localparam logic [63:0] HEAP      = 64'(NG) << MIN_BLOCK_LOG;
    localparam logic [31:0] TOP_BYTES = 32'd1 << (MIN_BLOCK_LOG + TOP_ORDER);
    localparam logic [OFF_W-1:0] GRAN_MASK = OFF_W'((64'd1 << MIN_BLOCK_LOG) - 64'd1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_A_CHK  = 4'd1;
    localparam logic [3:0] S_A_FIT  = 4'd2;
    localparam logic [3:0] S_A_SRD  = 4'd3;
    localparam logic [3:0] S_A_STST = 4'd4;
    localparam logic [3:0] S_A_SCHK = 4'd5;
    localparam logic [3:0] S_A_SRD2 = 4'd6;
    localparam logic [3:0] S_A_SWR  = 4'd7;
    localparam logic [3:0] S_A_DONE = 4'd8;
    localparam logic [3:0] S_F_CHK  = 4'd9;
    localparam logic [3:0] S_F_AO   = 4'd10;
    localparam logic [3:0] S_F_RD   = 4'd11;
    localparam logic [3:0] S_F_TEST = 4'd12;
    localparam logic [3:0] S_F_SET  = 4'd13;
    localparam logic [3:0] S_F_SETW = 4'd14;
    localparam logic [3:0] S_RES    = 4'd15;

    logic [HDR_W-1:0]  header_bytes;
    logic [3:0]        state_reg;
    logic              clr_busy_reg;
    logic [CLRW-1:0]   clr_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [NEED_W-1:0] need_reg;
    order_t            o_reg;
    order_t            freed_reg;
    logic [GW-1:0]     idx_reg;
    logic [GW-1:0]     gran_reg;
    logic [AW-1:0]     ptr_reg;
    logic [CW-1:0]     cnt_reg [0:ORD_N-1];
    status_t           res_status_reg;
    logic [OFF_W-1:0]  res_off_reg;
    order_t            res_ord_reg;
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [OFF_W-1:0]  out_off_reg;
    order_t            out_ord_reg;

    logic [AW-1:0]     wbase [0:ORD_N-1];
    logic              buddy_sel;
    logic [GW-1:0]     bit_idx;
    logic [WORD_LOG-1:0] bit_pos;
    logic [AW-1:0]     addr_calc;
    logic [WORD_W-1:0] bit_mask;
    logic [WORD_LOG-1:0] lsb;
    logic [AW-1:0]     word_off;
    logic [GW-1:0]     scan_idx;
    logic [31:0]       ob_cur;
    logic [31:0]       ob_dn;
    logic [GW-1:0]     alloc_gran;
    logic [WORD_W-1:0] init_word;
    logic              cnt_inc;
    logic              cnt_dec;

    logic              fm_we;
    logic [AW-1:0]     fm_waddr;
    logic [WORD_W-1:0] fm_wdata;
    logic [AW-1:0]     fm_raddr;
    logic [WORD_W-1:0] fm_rdata;
    logic              ao_we;
    logic [GW-1:0]     ao_waddr;
    order_t            ao_wdata;
    logic [GW-1:0]     ao_raddr;
    order_t            ao_rdata;

    bba_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .header_bytes (header_bytes)
    );

    // free map: one bit per block of every order, packed 32 to a word
    bba_ram #(.W(WORD_W), .DEPTH(FM_DEPTH)) u_fm_ram (
        .clk   (clk),
        .we    (fm_we),
        .waddr (fm_waddr),
        .wdata (fm_wdata),
        .raddr (fm_raddr),
        .rdata (fm_rdata)
    );

    // per granule: order plus one of the allocated block starting there
    bba_ram #(.W(ORD_W), .DEPTH(NG)) u_ao_ram (
        .clk   (clk),
        .we    (ao_we),
        .waddr (ao_waddr),
        .wdata (ao_wdata),
        .raddr (ao_raddr),
        .rdata (ao_rdata)
    );

    // word base of each order
    for (genvar k = 0; k < ORD_N; k++)
    begin : g_wbase
        if (k <= TOP_ORDER)
        begin : g_used
            assign wbase[k] = AW'(bba_word_base(k, NG));
        end
        else
        begin : g_unused
            assign wbase[k] = '0;
        end
    end

    // handshake
    assign req.ready          = (state_reg == S_IDLE) && !clr_busy_reg;
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.granted_offset = out_off_reg;
    assign rsp.granted_order  = out_ord_reg;

    // shared address unit: word and bit of block idx (or its buddy) at o_reg
    assign buddy_sel = (state_reg == S_A_SRD2) || (state_reg == S_A_SWR) ||
                       (state_reg == S_F_RD)   || (state_reg == S_F_TEST);
    assign bit_idx   = idx_reg ^ GW'(buddy_sel);
    assign bit_pos   = WORD_LOG'(bit_idx);
    assign addr_calc = wbase[o_reg] + AW'(bit_idx >> WORD_LOG);
    assign bit_mask  = WORD_W'(1) << bit_pos;

    // block sizes at and below the current order
    assign ob_cur = 32'd1 << (MIN_BLOCK_LOG + int'(o_reg));
    assign ob_dn  = 32'd1 << (MIN_BLOCK_LOG + int'(o_reg) - 1);

    assign alloc_gran = GW'(idx_reg << o_reg);

    // lowest set bit of the scanned word
    always_comb
    begin
        lsb = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (fm_rdata[j])
            begin
                lsb = WORD_LOG'(j);
            end
        end
    end

    assign word_off = ptr_reg - wbase[o_reg];
    assign scan_idx = GW'({word_off, lsb});

    // reset image of a free map word: only top order blocks free
    always_comb
    begin
        init_word = '0;
        if (int'(clr_reg) >= WBT)
        begin
            for (int j = 0; j < WORD_W; j++)
            begin
                init_word[j] = (((int'(clr_reg) - WBT) << WORD_LOG) + j) < TOP_BLOCKS;
            end
        end
    end

    // free count updates
    assign cnt_dec = ((state_reg == S_A_STST) && (fm_rdata != '0)) ||
                     ((state_reg == S_F_TEST) && fm_rdata[bit_pos]);
    assign cnt_inc = ((state_reg == S_A_SWR) || (state_reg == S_F_SETW)) &&
                     !fm_rdata[bit_pos];

    // free map port control
    always_comb
    begin
        fm_we    = 1'b0;
        fm_waddr = addr_calc;
        fm_wdata = fm_rdata;
        fm_raddr = (state_reg == S_A_SRD) ? ptr_reg : addr_calc;
        if (clr_busy_reg)
        begin
            fm_we    = int'(clr_reg) < FM_DEPTH;
            fm_waddr = AW'(clr_reg);
            fm_wdata = init_word;
        end
        else
        begin
            unique case (state_reg)
                S_A_STST:
                begin
                    fm_we    = fm_rdata != '0;
                    fm_waddr = ptr_reg;
                    fm_wdata = fm_rdata & ~(WORD_W'(1) << lsb);
                end
                S_A_SWR, S_F_SETW:
                begin
                    fm_we    = 1'b1;
                    fm_wdata = fm_rdata | bit_mask;
                end
                S_F_TEST:
                begin
                    fm_we    = fm_rdata[bit_pos];
                    fm_wdata = fm_rdata & ~bit_mask;
                end
                default:
                begin
                    fm_we = 1'b0;
                end
            endcase
        end
    end

    // granule order table port control
    always_comb
    begin
        ao_we    = 1'b0;
        ao_waddr = gran_reg;
        ao_wdata = '0;
        ao_raddr = GW'(off_reg >> MIN_BLOCK_LOG);
        if (clr_busy_reg)
        begin
            ao_we    = int'(clr_reg) < NG;
            ao_waddr = GW'(clr_reg);
        end
        else if (state_reg == S_F_AO)
        begin
            ao_we = (ao_rdata != '0) && (ao_rdata <= ORD_W'(TOP_ORDER + 1));
        end
        else if (state_reg == S_A_DONE)
        begin
            ao_we    = 1'b1;
            ao_waddr = alloc_gran;
            ao_wdata = o_reg + order_t'(1);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clr_busy_reg  <= 1'b1;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < ORD_N; k++)
            begin
                cnt_reg[k] <= (k == TOP_ORDER) ? CW'(TOP_BLOCKS) : '0;
            end
        end
        else
        begin
            // clearing pass
            if (clr_busy_reg)
            begin
                clr_reg <= clr_reg + CLRW'(1);
                if (int'(clr_reg) == CLR_N - 1)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end

            // output beat taken; a new result loads in S_RES instead
            if (rsp.valid && rsp.ready && (state_reg != S_RES))
            begin
                out_valid_reg <= 1'b0;
            end

            if (cnt_dec)
            begin
                cnt_reg[o_reg] <= cnt_reg[o_reg] - CW'(1);
            end
            else if (cnt_inc)
            begin
                cnt_reg[o_reg] <= cnt_reg[o_reg] + CW'(1);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        req_reg   <= req.request_bytes;
                        off_reg   <= req.block_offset;
                        need_reg  <= NEED_W'(req.request_bytes) + NEED_W'(header_bytes);
                        state_reg <= (req.command == CMD_FREE) ? S_F_CHK : S_A_CHK;
                    end
                end
                S_A_CHK:
                begin
                    if ((req_reg == '0) || (32'(need_reg) > TOP_BYTES))
                    begin
                        res_status_reg <= ST_SIZE;
                        res_off_reg    <= '0;
                        res_ord_reg    <= '0;
                        state_reg      <= S_RES;
                    end
                    else
                    begin
                        o_reg     <= '0;
                        state_reg <= S_A_FIT;
                    end
                end
                // smallest fitting order with a free block
                S_A_FIT:
                begin
                    if ((ob_cur >= 32'(need_reg)) && (cnt_reg[o_reg] != '0))
                    begin
                        ptr_reg   <= wbase[o_reg];
                        state_reg <= S_A_SRD;
                    end
                    else if (o_reg == ORD_W'(TOP_ORDER))
                    begin
                        res_status_reg <= ST_NOFREE;
                        res_off_reg    <= '0;
                        res_ord_reg    <= '0;
                        state_reg      <= S_RES;
                    end
                    else
                    begin
                        o_reg <= o_reg + order_t'(1);
                    end
                end
                S_A_SRD:
                begin
                    state_reg <= S_A_STST;
                end
                // word scan for the lowest free block
                S_A_STST:
                begin
                    if (fm_rdata != '0)
                    begin
                        idx_reg   <= scan_idx;
                        state_reg <= S_A_SCHK;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg + AW'(1);
                        state_reg <= S_A_SRD;
                    end
                end
                // split while the lower half still fits
                S_A_SCHK:
                begin
                    if ((o_reg != '0) && (ob_dn >= 32'(need_reg)))
                    begin
                        o_reg     <= o_reg - order_t'(1);
                        idx_reg   <= idx_reg << 1;
                        state_reg <= S_A_SRD2;
                    end
                    else
                    begin
                        state_reg <= S_A_DONE;
                    end
                end
                S_A_SRD2:
                begin
                    state_reg <= S_A_SWR;
                end
                S_A_SWR:
                begin
                    state_reg <= S_A_SCHK;
                end
                S_A_DONE:
                begin
                    res_status_reg <= ST_OK;
                    res_off_reg    <= OFF_W'(64'(alloc_gran) << MIN_BLOCK_LOG);
                    res_ord_reg    <= o_reg;
                    state_reg      <= S_RES;
                end
                S_F_CHK:
                begin
                    if ((64'(off_reg) >= HEAP) || ((off_reg & GRAN_MASK) != '0))
                    begin
                        res_status_reg <= ST_BADFREE;
                        res_off_reg    <= '0;
                        res_ord_reg    <= '0;
                        state_reg      <= S_RES;
                    end
                    else
                    begin
                        gran_reg  <= GW'(off_reg >> MIN_BLOCK_LOG);
                        state_reg <= S_F_AO;
                    end
                end
                S_F_AO:
                begin
                    if ((ao_rdata == '0) || (ao_rdata > ORD_W'(TOP_ORDER + 1)))
                    begin
                        res_status_reg <= ST_BADFREE;
                        res_off_reg    <= '0;
                        res_ord_reg    <= '0;
                        state_reg      <= S_RES;
                    end
                    else
                    begin
                        o_reg     <= ao_rdata - order_t'(1);
                        freed_reg <= ao_rdata - order_t'(1);
                        idx_reg   <= gran_reg >> (ao_rdata - order_t'(1));
                        state_reg <= S_F_RD;
                    end
                end
                // merge loop: buddy read issued here
                S_F_RD:
                begin
                    state_reg <= (o_reg == ORD_W'(TOP_ORDER)) ? S_F_SET : S_F_TEST;
                end
                S_F_TEST:
                begin
                    if (fm_rdata[bit_pos])
                    begin
                        idx_reg   <= idx_reg >> 1;
                        o_reg     <= o_reg + order_t'(1);
                        state_reg <= S_F_RD;
                    end
                    else
                    begin
                        state_reg <= S_F_SET;
                    end
                end
                S_F_SET:
                begin
                    state_reg <= S_F_SETW;
                end
                S_F_SETW:
                begin
                    res_status_reg <= ST_OK;
                    res_off_reg    <= '0;
                    res_ord_reg    <= freed_reg;
                    state_reg      <= S_RES;
                end
                // hand the result to the output register
                S_RES:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_off_reg    <= res_off_reg;
                        out_ord_reg    <= res_ord_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[bench/tb_buddy_block_allocator_unit.sv]
`default_nettype none
module tb_buddy_block_allocator_unit;
    import bba_pkg::*;

    localparam int NUM_GRAN   = 32 << 10;
    localparam int MAP_DEPTH  = 32 * 2047;
    localparam int TOP_ORD    = 10;
    localparam int GRAN_LOG   = 7;
    localparam int MAX_CYCLES = 20_000_000;

    typedef struct packed {
        status_t          st;
        logic [OFF_W-1:0] off;
        order_t           ord;
    } rsp_beat_t;

    // buddy heap predictor plus queue of pending response beats
    class bba_scoreboard;
        bit           free_map[MAP_DEPTH];
        logic [3:0]   alloc_ord[NUM_GRAN];
        int unsigned  obase[TOP_ORD+1];
        int unsigned  hdr;
        rsp_beat_t    pending_rsp[$];
        int unsigned  live_blocks[$];
        int unsigned  freed_blocks[$];
        int           errors;

        function new();
            obase[0] = 0;
            for (int o = 1; o <= TOP_ORD; o++)
            begin
                obase[o] = obase[o-1] + (NUM_GRAN >> (o - 1));
            end
            foreach (free_map[i]) free_map[i] = 0;
            foreach (alloc_ord[i]) alloc_ord[i] = 0;
            for (int i = 0; i < 32; i++)
            begin
                free_map[obase[TOP_ORD] + i] = 1;
            end
            hdr    = 32'(HDR_RESET);
            errors = 0;
        endfunction

        function void set_header(int unsigned v);
            hdr = v & 8'h7f;
        endfunction

        function void drop_live(int unsigned off);
            foreach (live_blocks[i])
            begin
                if (live_blocks[i] == off)
                begin
                    live_blocks.delete(i);
                    break;
                end
            end
            freed_blocks.push_back(off);
            if (freed_blocks.size() > 64) void'(freed_blocks.pop_front());
        endfunction

        function rsp_beat_t predict_alloc(int unsigned rq);
            rsp_beat_t   r;
            int unsigned need;
            int unsigned idx;
            int unsigned gran;
            int          o;
            bit          found;
            r    = '0;
            need = rq + hdr;
            idx  = 0;
            found = 0;
            if (rq == 0 || need > (128 << TOP_ORD))
            begin
                r.st = ST_SIZE;
                return r;
            end
            for (o = 0; o <= TOP_ORD; o++)
            begin
                if ((128 << o) < need) continue;
                for (int unsigned i = 0; i < (NUM_GRAN >> o); i++)
                begin
                    if (free_map[obase[o] + i])
                    begin
                        idx   = i;
                        found = 1;
                        break;
                    end
                end
                if (found) break;
            end
            if (!found)
            begin
                r.st = ST_NOFREE;
                return r;
            end
            free_map[obase[o] + idx] = 0;
            // split down, freeing upper halves
            while (o > 0 && (128 << (o - 1)) >= need)
            begin
                o--;
                idx = idx << 1;
                free_map[obase[o] + idx + 1] = 1;
            end
            gran = idx << o;
            alloc_ord[gran] = 4'(o + 1);
            r.st  = ST_OK;
            r.off = OFF_W'(gran << GRAN_LOG);
            r.ord = order_t'(o);
            live_blocks.push_back(gran << GRAN_LOG);
            return r;
        endfunction

        function rsp_beat_t predict_free(int unsigned off);
            rsp_beat_t   r;
            int unsigned gran;
            int unsigned idx;
            int unsigned bpos;
            int          o;
            r = '0;
            if (off >= (NUM_GRAN << GRAN_LOG) || (off & 127) != 0)
            begin
                r.st = ST_BADFREE;
                return r;
            end
            gran = off >> GRAN_LOG;
            if (alloc_ord[gran] == 0 || alloc_ord[gran] > TOP_ORD + 1)
            begin
                r.st = ST_BADFREE;
                return r;
            end
            o = alloc_ord[gran] - 1;
            r.st  = ST_OK;
            r.ord = order_t'(o);
            alloc_ord[gran] = 0;
            idx = gran >> o;
            // merge while buddy is a whole free block
            while (o < TOP_ORD)
            begin
                bpos = obase[o] + (idx ^ 1);
                if (!free_map[bpos]) break;
                free_map[bpos] = 0;
                idx = idx >> 1;
                o++;
            end
            free_map[obase[o] + idx] = 1;
            drop_live(off);
            return r;
        endfunction

        function void note_request(logic cmd, logic [REQ_W-1:0] rq, logic [OFF_W-1:0] off);
            if (cmd == CMD_ALLOC) pending_rsp.push_back(predict_alloc(32'(rq)));
            else pending_rsp.push_back(predict_free(32'(off)));
        endfunction

        function void check_response(status_t st, logic [OFF_W-1:0] off, order_t ord);
            rsp_beat_t e;
            if (pending_rsp.size() == 0)
            begin
                $error("response beat with nothing expected: status %0d", st);
                errors++;
                return;
            end
            e = pending_rsp.pop_front();
            if (st !== e.st)
            begin
                $error("status expected %0d actual %0d", e.st, st);
                errors++;
            end
            if (off !== e.off)
            begin
                $error("granted_offset expected %0h actual %0h", e.off, off);
                errors++;
            end
            if (ord !== e.ord)
            begin
                $error("granted_order expected %0d actual %0d", e.ord, ord);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    bba_req_if req ();
    bba_rsp_if rsp ();

    buddy_block_allocator_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req.sink),
        .rsp     (rsp.source)
    );

    bba_scoreboard sb = new();
    int  cycles = 0;
    bit  no_gaps = 0;
    int  rsp_hold = 0;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("tb_buddy_block_allocator_unit failed");
            $finish;
        end
    end

    // accepted request and response beats
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            sb.note_request(req.command, req.request_bytes, req.block_offset);
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_response(rsp.status, rsp.granted_offset, rsp.granted_order);
    end

    // response side stalls: mostly short, some long, stretches of none
    always @(negedge clk)
    begin
        if (rsp_hold == 0)
        begin
            if ($urandom_range(0, 99) < 60 || no_gaps)
            begin
                rsp.ready <= 1'b1;
                rsp_hold = $urandom_range(1, 20);
            end
            else
            begin
                rsp.ready <= 1'b0;
                rsp_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                       : $urandom_range(1, 3);
            end
        end
        else
            rsp_hold--;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_beat(logic cmd, int unsigned rq, int unsigned off);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.command       = cmd;
        req.request_bytes = REQ_W'(rq);
        req.block_offset  = OFF_W'(off);
        req.valid         = 1'b1;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
    endtask

    task automatic write_header(int unsigned v);
        @(negedge clk);
        req.valid = 1'b0;
        psel      = 1'b1;
        pwrite    = 1'b1;
        penable   = 1'b0;
        paddr     = {REG_HDR, 2'b00};
        pwdata    = v;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        sb.set_header(v);
    endtask

    task automatic drain();
        while (sb.pending_rsp.size() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic free_live();
        int unsigned n;
        n = $urandom_range(0, sb.live_blocks.size() - 1);
        send_beat(CMD_FREE, $urandom, sb.live_blocks[n]);
    endtask

    // one random beat; fill mode leans on large allocations to exhaust the heap
    task automatic random_beat(bit fill);
        int r;
        int unsigned rq;
        int unsigned off;
        r = $urandom_range(0, 99);
        if (r < (fill ? 65 : 45))
        begin
            r = $urandom_range(0, 99);
            if (fill && r < 70) rq = $urandom_range(30000, 131072);
            else if (r < 75) rq = $urandom_range(1, 2000);
            else if (r < 95) rq = $urandom_range(1, 131072);
            else rq = 0;
            send_beat(CMD_ALLOC, rq, $urandom_range(0, 4194303));
        end
        else if (r < 88 && sb.live_blocks.size() > 0)
            free_live();
        else
        begin
            r = $urandom_range(0, 3);
            if (r == 0 && sb.freed_blocks.size() > 0)
                off = sb.freed_blocks[$urandom_range(0, sb.freed_blocks.size() - 1)];
            else if (r == 1) off = $urandom_range(0, 4194303) & ~32'd127;
            else off = $urandom_range(0, 4194303);
            send_beat(CMD_FREE, $urandom_range(0, 262143), off);
        end
    endtask

    task automatic run_phase(int n, bit fill);
        for (int i = 0; i < n; i++)
        begin
            if (i % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            random_beat(fill);
        end
        no_gaps = 0;
        @(negedge clk);
        req.valid = 1'b0;
        drain();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req.valid         = 1'b0;
        req.command       = CMD_ALLOC;
        req.request_bytes = '0;
        req.block_offset  = '0;
        rsp.ready         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: size edges, exact fits, bad frees, double free
        send_beat(CMD_ALLOC, 1, 0);
        send_beat(CMD_ALLOC, 0, 0);
        send_beat(CMD_ALLOC, 131072, 0);
        send_beat(CMD_ALLOC, 131072 - 40, 0);
        send_beat(CMD_ALLOC, 131072 - 39, 0);
        send_beat(CMD_ALLOC, 88, 0);
        send_beat(CMD_ALLOC, 89, 0);
        send_beat(CMD_ALLOC, 262143, 4194303);
        send_beat(CMD_FREE, 0, 1);
        send_beat(CMD_FREE, 0, 4194303);
        send_beat(CMD_FREE, 0, 4194304 - 128);
        send_beat(CMD_FREE, 0, 128);
        send_beat(CMD_FREE, 0, 0);
        send_beat(CMD_FREE, 262143, 0);
        send_beat(CMD_ALLOC, 5000, 0);
        send_beat(CMD_FREE, 0, 131072);
        send_beat(CMD_FREE, 0, 131072);
        @(negedge clk);
        req.valid = 1'b0;
        drain();

        run_phase(340, 0);
        write_header(0);
        send_beat(CMD_ALLOC, 128, 0);
        send_beat(CMD_ALLOC, 131072, 0);
        run_phase(360, 1);
        write_header(127);
        send_beat(CMD_ALLOC, 1, 0);
        send_beat(CMD_ALLOC, 131072 - 127, 0);
        run_phase(360, 0);
        write_header($urandom_range(0, 127));
        run_phase(360, 1);

        if (sb.errors == 0)
            $display("tb_buddy_block_allocator_unit passed");
        else
            $display("tb_buddy_block_allocator_unit failed");
        $finish;
    end
endmodule
`default_nettype wire

[buddy_block_allocator_unit.f]
rtl/bba_pkg.sv
rtl/bba_if.sv
rtl/bba_ram.sv
rtl/bba_cfg.sv
rtl/buddy_block_allocator_unit.sv
bench/tb_buddy_block_allocator_unit.sv
